[rtl/dqar_pkg.sv]
// Package for the DNS query answer rewriter: command and state types,
// sizes, and the header and answer byte tables.
// No dependencies.
package dqar_pkg;

    localparam int MAX_LEN_DEF = 512;
    localparam int HDR_BYTES   = 12;
    localparam int ANS_BYTES   = 16;
    localparam int CQ_DEPTH    = 4;
    localparam int CQ_AW       = 2;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic REG_ANSWER_ADDRESS = 1'b0;

    localparam logic [15:0] RESP_FLAGS = 16'h8180;

    typedef enum logic [1:0] {
        CMD_HEADER,
        CMD_ECHO,
        CMD_ANSWER
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic        ans;
        logic [31:0] data;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_HDR,
        B_ECHO,
        B_ANS
    } back_state_t;

    // snap = {id_hi, id_lo, qdcount_hi, qdcount_lo}
    function automatic logic [7:0] header_byte(input logic [3:0] idx, input logic [31:0] snap);
        logic [7:0] b;
        case (idx)
            4'd0:    b = snap[31:24];
            4'd1:    b = snap[23:16];
            4'd2:    b = RESP_FLAGS[15:8];
            4'd3:    b = RESP_FLAGS[7:0];
            4'd4:    b = snap[15:8];
            4'd5:    b = snap[7:0];
            4'd7:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] answer_byte(input logic [3:0] idx, input logic [31:0] addr);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'hC0;
            4'd1:    b = 8'h0C;
            4'd3:    b = 8'h01;
            4'd5:    b = 8'h01;
            4'd8:    b = 8'h01;
            4'd9:    b = 8'h2C;
            4'd11:   b = 8'h04;
            4'd12:   b = addr[31:24];
            4'd13:   b = addr[23:16];
            4'd14:   b = addr[15:8];
            4'd15:   b = addr[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[rtl/dqar_front.sv]
// Front end: accepts query bytes, holds the header fields, checks the header
// and turns it, echoed bytes and the query end into commands. Uses dqar_pkg.
module dqar_front #(
    parameter int MAX_LEN = dqar_pkg::MAX_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_stall,
    input  logic [7:0]        rx_byte,
    input  logic              rx_last,
    input  logic              q_full,
    output logic              q_push,
    output dqar_pkg::cmd_t    q_cmd
);
    import dqar_pkg::*;

    localparam int IW = $clog2(MAX_LEN + 1);

    logic [IW-1:0] idx_reg, idx_next;
    logic          drop_reg, drop_next;
    logic [7:0]    id_hi_reg, id_lo_reg, qd_hi_reg, qd_lo_reg;
    logic          qr_reg;

    logic accept;
    logic at_check, in_range, bad_hdr, hdr_ok, drop_now, echo, ans;

    assign rx_stall = q_full;
    assign accept   = rx_valid && !rx_stall;

    assign at_check = (idx_reg == IW'(HDR_BYTES - 1));
    assign in_range = (idx_reg < IW'(MAX_LEN));
    assign bad_hdr  = qr_reg || (qd_hi_reg == 8'h00 && qd_lo_reg == 8'h00);
    assign hdr_ok   = !drop_reg && at_check && !bad_hdr;
    assign drop_now = !drop_reg && at_check && bad_hdr;
    assign echo     = !drop_reg && in_range && (idx_reg >= IW'(HDR_BYTES));
    assign ans      = rx_last && !drop_reg && !drop_now && (idx_reg >= IW'(HDR_BYTES - 1));

    always_comb
    begin
        q_cmd      = '0;
        q_cmd.op   = CMD_ANSWER;
        q_cmd.ans  = ans;
        if (hdr_ok)
        begin
            q_cmd.op   = CMD_HEADER;
            q_cmd.data = {id_hi_reg, id_lo_reg, qd_hi_reg, qd_lo_reg};
        end
        else if (echo)
        begin
            q_cmd.op   = CMD_ECHO;
            q_cmd.data = {24'h000000, rx_byte};
        end
        q_push = accept && (hdr_ok || echo || ans);
    end

    always_comb
    begin
        idx_next  = idx_reg;
        drop_next = drop_reg;
        if (accept)
        begin
            if (rx_last)
            begin
                idx_next  = '0;
                drop_next = 1'b0;
            end
            else
            begin
                if (in_range)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                drop_next = drop_reg || drop_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            drop_reg <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (idx_reg == IW'(0))
            begin
                id_hi_reg <= rx_byte;
            end
            if (idx_reg == IW'(1))
            begin
                id_lo_reg <= rx_byte;
            end
            if (idx_reg == IW'(2))
            begin
                qr_reg <= rx_byte[7];
            end
            if (idx_reg == IW'(4))
            begin
                qd_hi_reg <= rx_byte;
            end
            if (idx_reg == IW'(5))
            begin
                qd_lo_reg <= rx_byte;
            end
        end
    end

endmodule

[rtl/dqar_cmd_queue.sv]
// Short command queue between front and back end.
// Uses dqar_pkg for the command type and depth.
module dqar_cmd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dqar_pkg::cmd_t    push_cmd,
    output logic              full,
    input  logic              pop,
    output dqar_pkg::cmd_t    pop_cmd,
    output logic              empty
);
    import dqar_pkg::*;

    cmd_t              mem_reg [CQ_DEPTH];
    logic [CQ_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CQ_AW:0]    count_reg;

    assign full    = (count_reg == (CQ_AW + 1)'(CQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/dqar_back.sv]
// Back end: sequencer that carries out queued commands and drives the
// response byte stream through an output register. Uses dqar_pkg.
module dqar_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       answer_address,
    input  logic              q_empty,
    input  dqar_pkg::cmd_t    q_cmd,
    output logic              q_pop,
    output logic              tx_valid,
    input  logic              tx_stall,
    output logic [7:0]        tx_byte,
    output logic              tx_last
);
    import dqar_pkg::*;

    back_state_t state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    cmd_t        cmd_reg, cmd_next;

    logic        tx_valid_reg, tx_valid_next;
    logic [7:0]  tx_byte_reg;
    logic        tx_last_reg;

    logic        out_ready, gen_valid, gen_last, advance;
    logic [7:0]  gen_byte;

    assign out_ready = !tx_valid_reg || !tx_stall;
    assign advance   = gen_valid && out_ready;

    always_comb
    begin
        q_pop     = 1'b0;
        gen_valid = 1'b0;
        gen_byte  = 8'h00;
        gen_last  = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                q_pop = !q_empty;
            end
            B_HDR:
            begin
                gen_valid = 1'b1;
                gen_byte  = header_byte(cnt_reg, cmd_reg.data);
            end
            B_ECHO:
            begin
                gen_valid = 1'b1;
                gen_byte  = cmd_reg.data[7:0];
            end
            B_ANS:
            begin
                gen_valid = 1'b1;
                gen_byte  = answer_byte(cnt_reg, answer_address);
                gen_last  = (cnt_reg == 4'(ANS_BYTES - 1));
            end
            default:
            begin
                gen_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd_next   = cmd_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    cmd_next = q_cmd;
                    cnt_next = '0;
                    case (q_cmd.op)
                        CMD_HEADER: state_next = B_HDR;
                        CMD_ECHO:   state_next = B_ECHO;
                        CMD_ANSWER: state_next = B_ANS;
                        default:    state_next = B_IDLE;
                    endcase
                end
            end
            B_HDR:
            begin
                if (advance)
                begin
                    if (cnt_reg == 4'(HDR_BYTES - 1))
                    begin
                        cnt_next   = '0;
                        state_next = cmd_reg.ans ? B_ANS : B_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            B_ECHO:
            begin
                if (advance)
                begin
                    cnt_next   = '0;
                    state_next = cmd_reg.ans ? B_ANS : B_IDLE;
                end
            end
            B_ANS:
            begin
                if (advance)
                begin
                    if (cnt_reg == 4'(ANS_BYTES - 1))
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign tx_valid_next = out_ready ? gen_valid : tx_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            cnt_reg      <= '0;
            tx_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            tx_valid_reg <= tx_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (advance)
        begin
            tx_byte_reg <= gen_byte;
            tx_last_reg <= gen_last;
        end
    end

    assign tx_valid = tx_valid_reg;
    assign tx_byte  = tx_byte_reg;
    assign tx_last  = tx_last_reg;

endmodule

[rtl/dns_query_answer_rewriter_unit.sv]
// After the 12th query byte is accepted, the header command passes the queue, the back-end
// state register and the output register to tx. Each echoed byte needs an idle step to fetch
// it and an echo step; header 12 bytes, answer 16; rx stalls only while the queue is full.
// Reset: rst_n clears counters, flags, queue and output valid; no sweep.
// Top level of the DNS query answer rewriter; uses dqar_pkg, dqar_front,
// dqar_cmd_queue and dqar_back.
module dns_query_answer_rewriter_unit #(
    parameter int MAX_LEN = dqar_pkg::MAX_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rx_valid,
    output logic                          rx_stall,
    input  logic [7:0]                    rx_byte,
    input  logic                          rx_last,
    output logic                          tx_valid,
    input  logic                          tx_stall,
    output logic [7:0]                    tx_byte,
    output logic                          tx_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dqar_pkg::APB_AW-1:0]   paddr,
    input  logic [dqar_pkg::APB_DW-1:0]   pwdata,
    output logic [dqar_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import dqar_pkg::*;

    logic [31:0] answer_address_reg;
    logic        reg_index;
    logic        q_push, q_full, q_pop, q_empty;
    cmd_t        push_cmd, pop_cmd;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_AW-1];
    assign prdata    = (reg_index == REG_ANSWER_ADDRESS) ? answer_address_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answer_address_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_index == REG_ANSWER_ADDRESS)
        begin
            answer_address_reg <= pwdata;
        end
    end

    dqar_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .rx_byte  (rx_byte),
        .rx_last  (rx_last),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    dqar_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    dqar_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .answer_address (answer_address_reg),
        .q_empty        (q_empty),
        .q_cmd          (pop_cmd),
        .q_pop          (q_pop),
        .tx_valid       (tx_valid),
        .tx_stall       (tx_stall),
        .tx_byte        (tx_byte),
        .tx_last        (tx_last)
    );

endmodule

[rtl/dqar_checker.sv]
// Port-level checks for the DNS query answer rewriter, bound to the top level.
// Uses dqar_pkg.
module dqar_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rx_valid,
    input  logic                          rx_stall,
    input  logic [7:0]                    rx_byte,
    input  logic                          rx_last,
    input  logic                          tx_valid,
    input  logic                          tx_stall,
    input  logic [7:0]                    tx_byte,
    input  logic                          tx_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dqar_pkg::APB_AW-1:0]   paddr,
    input  logic [dqar_pkg::APB_DW-1:0]   pwdata,
    input  logic [dqar_pkg::APB_DW-1:0]   prdata,
    input  logic                          pready
);
    import dqar_pkg::*;

    logic tx_end;

    assign tx_end = tx_valid && !tx_stall && tx_last;

    a_rx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_stall |=> rx_valid && $stable(rx_byte) && $stable(rx_last))
        else $error("rx payload changed while stalled");

    a_tx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_stall |=> tx_valid && $stable(tx_byte) && $stable(tx_last))
        else $error("tx payload changed while stalled");

    a_no_back_to_back_end: assert property (@(posedge clk) disable iff (!rst_n)
        tx_end |=> !tx_end)
        else $error("two response ends in consecutive transfers");

    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[APB_AW-1] == REG_ANSWER_ADDRESS)
        ##1 (paddr[APB_AW-1] == REG_ANSWER_ADDRESS) |-> prdata == $past(pwdata))
        else $error("answer address readback mismatch");

    a_cfg_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
        psel && paddr[APB_AW-1] != REG_ANSWER_ADDRESS |-> prdata == '0)
        else $error("unmapped register read nonzero");

endmodule

bind dns_query_answer_rewriter_unit dqar_checker u_dqar_checker (.*);

[tb/dns_query_answer_rewriter_unit_tb.sv]
// Testbench for dns_query_answer_rewriter_unit: directed and random query datagrams
// against a cycle-free predictor of the rewritten response stream.
// Depends on dqar_pkg and the RTL of dns_query_answer_rewriter_unit.
module dns_query_answer_rewriter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dqar_pkg::*;

    localparam int MAX_LEN = MAX_LEN_DEF;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_BYTES = 300;
    localparam logic [APB_AW-1:0] ADDR_ANSWER = {REG_ANSWER_ADDRESS, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_UNUSED = 3'd4;
    localparam logic [95:0] ANSWER_FIXED = 96'hC00C_0001_0001_0000_012C_0004;
    localparam logic [15:0] QD_ONE = 16'h0001;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } tx_beat_t;

    logic clk;
    logic rst_n;
    logic rx_valid;
    logic rx_stall;
    logic [7:0] rx_byte;
    logic rx_last;
    logic tx_valid;
    logic tx_stall;
    logic [7:0] tx_byte;
    logic tx_last;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    // predictor state
    tx_beat_t response_q[$];
    logic [7:0] hdr_copy[HDR_BYTES];
    int unsigned query_pos;
    bit query_dropped;
    logic [31:0] answer_addr;

    logic [7:0] dgram[$];
    bit idle_on;
    int unsigned cycle_count;
    int unsigned fail_count;
    int unsigned dgram_count;
    int unsigned answered_count;
    int unsigned bytes_in;
    int unsigned beats_checked;

    dns_query_answer_rewriter_unit #(
        .MAX_LEN(MAX_LEN)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .rx_valid(rx_valid),
        .rx_stall(rx_stall),
        .rx_byte(rx_byte),
        .rx_last(rx_last),
        .tx_valid(tx_valid),
        .tx_stall(tx_stall),
        .tx_byte(tx_byte),
        .tx_last(tx_last),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t timeout after %0d cycles, %0d bytes still expected", $realtime,
                     cycle_count, response_q.size());
            $display("dns_query_answer_rewriter_unit regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        tx_stall <= idle_on && ($urandom_range(99) < 33);
    end

    always @(posedge clk)
    begin : response_check
        tx_beat_t want;
        if (rst_n && tx_valid && !tx_stall)
        begin
            if (response_q.size() == 0)
            begin
                fail_count++;
                $display("%0t unexpected transfer: expected none, actual byte %02h last %0b",
                         $realtime, tx_byte, tx_last);
            end
            else
            begin
                want = response_q.pop_front();
                beats_checked++;
                if (tx_byte !== want.data)
                begin
                    fail_count++;
                    $display("%0t tx_byte mismatch: expected %02h, actual %02h",
                             $realtime, want.data, tx_byte);
                end
                if (tx_last !== want.last)
                begin
                    fail_count++;
                    $display("%0t tx_last mismatch: expected %0b, actual %0b",
                             $realtime, want.last, tx_last);
                end
            end
        end
    end

    function automatic void push_beat(input logic [7:0] d, input logic l);
        tx_beat_t beat;
        beat.data = d;
        beat.last = l;
        response_q.push_back(beat);
    endfunction

    function automatic void predict_rx_byte(input logic [7:0] b, input logic l);
        int unsigned pos;
        pos = query_pos;
        if (pos < HDR_BYTES)
            hdr_copy[pos] = b;
        if (!query_dropped && pos < MAX_LEN)
        begin
            if (pos == HDR_BYTES - 1)
            begin
                if (hdr_copy[2][7] || (hdr_copy[4] == 8'h00 && hdr_copy[5] == 8'h00))
                    query_dropped = 1'b1;
                else
                begin
                    push_beat(hdr_copy[0], 1'b0);
                    push_beat(hdr_copy[1], 1'b0);
                    push_beat(RESP_FLAGS[15:8], 1'b0);
                    push_beat(RESP_FLAGS[7:0], 1'b0);
                    push_beat(hdr_copy[4], 1'b0);
                    push_beat(hdr_copy[5], 1'b0);
                    push_beat(QD_ONE[15:8], 1'b0);
                    push_beat(QD_ONE[7:0], 1'b0);
                    for (int k = 0; k < 4; k++)
                        push_beat(8'h00, 1'b0);
                end
            end
            else if (pos >= HDR_BYTES)
                push_beat(b, 1'b0);
        end
        if (l)
        begin
            if (!query_dropped && pos >= HDR_BYTES - 1)
            begin
                for (int k = 0; k < 12; k++)
                    push_beat(ANSWER_FIXED[95 - 8*k -: 8], 1'b0);
                push_beat(answer_addr[31:24], 1'b0);
                push_beat(answer_addr[23:16], 1'b0);
                push_beat(answer_addr[15:8], 1'b0);
                push_beat(answer_addr[7:0], 1'b1);
                answered_count++;
            end
            query_pos = 0;
            query_dropped = 1'b0;
        end
        else if (pos < MAX_LEN)
            query_pos = pos + 1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic l);
        while (idle_on && $urandom_range(99) < 33)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte <= b;
        rx_last <= l;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        predict_rx_byte(b, l);
        bytes_in++;
    endtask

    task automatic send_dgram();
        for (int i = 0; i < dgram.size(); i++)
            send_byte(dgram[i], i == dgram.size() - 1);
        dgram.delete();
        dgram_count++;
    endtask

    task automatic push_header(input logic [15:0] id, input logic [15:0] flags,
                               input logic [15:0] qd);
        dgram.push_back(id[15:8]);
        dgram.push_back(id[7:0]);
        dgram.push_back(flags[15:8]);
        dgram.push_back(flags[7:0]);
        dgram.push_back(qd[15:8]);
        dgram.push_back(qd[7:0]);
        for (int i = 0; i < 6; i++)
            dgram.push_back(8'($urandom));
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
            dgram.push_back(8'($urandom));
    endtask

    task automatic drain();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (response_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] a, input logic [31:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (a == ADDR_ANSWER)
            answer_addr = d;
        @(posedge clk);
    endtask

    task automatic apb_check_read(input logic [APB_AW-1:0] a, input logic [31:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= a;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
        begin
            fail_count++;
            $display("%0t prdata mismatch at %0d: expected %08h, actual %08h",
                     $realtime, a, want, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_short_datagrams();
        push_random(1);
        send_dgram();
        push_header(16'h1234, 16'h0100, QD_ONE);
        void'(dgram.pop_back());
        send_dgram();
        drain();
    endtask

    task automatic test_rejected_headers();
        // response bit set
        push_header(16'hBEEF, 16'h8000, QD_ONE);
        push_random(5);
        send_dgram();
        // no questions
        push_header(16'h0F0F, 16'h0100, 16'h0000);
        push_random(4);
        send_dgram();
        push_header(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_dgram();
        drain();
    endtask

    task automatic test_minimal_queries();
        push_header(16'hA5A5, 16'h0100, QD_ONE);
        send_dgram();
        push_header(16'h0000, 16'h0000, 16'h0100);
        push_random(1);
        send_dgram();
        drain();
    endtask

    task automatic test_register_access();
        apb_check_read(ADDR_ANSWER, 32'h0000_0000);
        apb_write(ADDR_ANSWER, 32'hFFFF_FFFF);
        apb_check_read(ADDR_ANSWER, 32'hFFFF_FFFF);
        apb_write(ADDR_UNUSED, 32'h1234_5678);
        apb_check_read(ADDR_ANSWER, 32'hFFFF_FFFF);
        push_header(16'hFFFF, 16'h7FFF, 16'hFFFF);
        dgram.push_back(8'hFF);
        dgram.push_back(8'h00);
        send_dgram();
        drain();
        apb_write(ADDR_ANSWER, 32'h8000_0001);
        apb_check_read(ADDR_ANSWER, 32'h8000_0001);
        push_header(16'h0001, 16'h0000, QD_ONE);
        dgram.push_back(8'h00);
        dgram.push_back(8'hFF);
        dgram.push_back(8'h55);
        dgram.push_back(8'hAA);
        send_dgram();
        drain();
    endtask

    task automatic test_overlong_datagrams();
        // two bytes past the limit are not echoed, the last one still ends the query
        push_header(16'h7E57, 16'h0100, QD_ONE);
        push_random(MAX_LEN + 2 - HDR_BYTES);
        send_dgram();
        push_header(16'h0BAD, 16'h0100, 16'h0002);
        push_random(3);
        send_dgram();
        drain();
    endtask

    task automatic random_datagram();
        int kind;
        logic [15:0] flags;
        logic [15:0] qd;
        kind = $urandom_range(99);
        flags = 16'($urandom);
        qd = 16'($urandom);
        if (qd == 16'h0000)
            qd = QD_ONE;
        if (kind < 70)
        begin
            flags[15] = 1'b0;
            push_header(16'($urandom), flags, qd);
            push_random($urandom_range(40));
        end
        else if (kind < 80)
        begin
            flags[15] = 1'b1;
            push_header(16'($urandom), flags, qd);
            push_random($urandom_range(20));
        end
        else if (kind < 88)
        begin
            flags[15] = 1'b0;
            push_header(16'($urandom), flags, 16'h0000);
            push_random($urandom_range(20));
        end
        else
            push_random($urandom_range(1, HDR_BYTES - 1));
        send_dgram();
    endtask

    task automatic random_phase(input int unsigned n_bytes, input bit with_idle);
        int unsigned stop_at;
        idle_on = with_idle;
        stop_at = bytes_in + n_bytes;
        while (bytes_in < stop_at)
            random_datagram();
        drain();
    endtask

    task automatic test_random_traffic();
        apb_write(ADDR_ANSWER, $urandom);
        random_phase(RANDOM_BYTES * 2 / 5, 1'b1);
        apb_write(ADDR_ANSWER, 32'h0000_0000);
        random_phase(RANDOM_BYTES * 3 / 10, 1'b0);
        apb_write(ADDR_ANSWER, $urandom);
        random_phase(RANDOM_BYTES * 3 / 10, 1'b1);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        rx_valid <= 1'b0;
        rx_byte <= 8'h00;
        rx_last <= 1'b0;
        tx_stall <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        cycle_count = 0;
        fail_count = 0;
        dgram_count = 0;
        answered_count = 0;
        bytes_in = 0;
        beats_checked = 0;
        idle_on = 1'b1;
        answer_addr = 32'h0000_0000;
        query_pos = 0;
        query_dropped = 1'b0;
        foreach (hdr_copy[i])
            hdr_copy[i] = 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_datagrams();
        test_rejected_headers();
        test_minimal_queries();
        test_register_access();
        test_overlong_datagrams();
        test_random_traffic();

        $display("%0d datagrams, %0d query bytes sent, %0d answered", dgram_count, bytes_in,
                 answered_count);
        $display("%0d response bytes checked; short, rejected, overlong and stalled cases run",
                 beats_checked);
        if (fail_count == 0 && response_q.size() == 0)
            $display("dns_query_answer_rewriter_unit regression: pass");
        else
            $display("dns_query_answer_rewriter_unit regression: fail");
        $finish;
    end
endmodule
